// ===== design/y2r_pkg.sv =====
// shared types and constants for the yuyv to rgb888 converter
`default_nettype none

package y2r_pkg;

    localparam int unsigned TERM_W = 19;

    typedef logic signed [TERM_W-1:0] t_term;

    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;
    localparam logic [7:0] CHANNEL_MAX   = 8'd255;
    localparam t_term      ROUND_BIAS    = 19'sd128;
    localparam t_term      COEF_LUMA     = 19'sd298;
    localparam t_term      COEF_R_V      = 19'sd409;
    localparam t_term      COEF_G_U      = 19'sd100;
    localparam t_term      COEF_G_V      = 19'sd208;
    localparam t_term      COEF_B_U      = 19'sd516;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       tail_single;
        logic       red_chroma_present;
    } t_yuyv_req;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       second_valid;
    } t_rgb_res;

    typedef struct packed {
        t_term red;
        t_term green;
        t_term blue;
    } t_chroma_terms;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

endpackage

`default_nettype wire

// ===== design/y2r_chroma.sv =====
// shared chroma term stage: registered r, g, b chroma contributions
`default_nettype none

module y2r_chroma (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [7:0]             i_chroma_blue,
    input  wire logic [7:0]             i_chroma_red,
    input  wire logic                   i_tail_single,
    input  wire logic                   i_red_chroma_present,
    output y2r_pkg::t_chroma_terms      o_terms
);

    logic signed [9:0]      d;
    logic signed [9:0]      e;
    y2r_pkg::t_term         dx;
    y2r_pkg::t_term         ex;
    y2r_pkg::t_chroma_terms n_terms;
    y2r_pkg::t_chroma_terms r_terms;

    always_comb begin
        d = $signed({2'b00, i_chroma_blue}) - $signed({2'b00, y2r_pkg::CHROMA_OFFSET});
        if (i_tail_single && !i_red_chroma_present) begin
            e = 10'sd0;
        end else begin
            e = $signed({2'b00, i_chroma_red}) - $signed({2'b00, y2r_pkg::CHROMA_OFFSET});
        end
        dx = y2r_pkg::t_term'(d);
        ex = y2r_pkg::t_term'(e);
        n_terms.red   = ex * y2r_pkg::COEF_R_V;
        n_terms.green = 19'sd0 - dx * y2r_pkg::COEF_G_U - ex * y2r_pkg::COEF_G_V;
        n_terms.blue  = dx * y2r_pkg::COEF_B_U;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

`default_nettype wire

// ===== design/y2r_lane.sv =====
// one pixel lane: registered luma term, then sum, round and clamp per channel
`default_nettype none

module y2r_lane (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [7:0]             i_luma,
    input  wire y2r_pkg::t_chroma_terms i_terms,
    output y2r_pkg::t_pixel             o_pixel
);

    logic [7:0]     c;
    y2r_pkg::t_term n_luma_term;
    y2r_pkg::t_term r_luma_term;

    function automatic logic [7:0] clamp_channel(input y2r_pkg::t_term sum);
        y2r_pkg::t_term t;
        t = sum + y2r_pkg::ROUND_BIAS;
        if (t[y2r_pkg::TERM_W-1]) begin
            return 8'd0;
        end else if (t[y2r_pkg::TERM_W-2:16] != '0) begin
            return y2r_pkg::CHANNEL_MAX;
        end else begin
            return t[15:8];
        end
    endfunction

    always_comb begin
        c = (i_luma < y2r_pkg::LUMA_OFFSET) ? 8'd0 : i_luma - y2r_pkg::LUMA_OFFSET;
        n_luma_term = y2r_pkg::t_term'($signed({1'b0, c})) * y2r_pkg::COEF_LUMA;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_luma_term <= n_luma_term;
        end
    end

    always_comb begin
        o_pixel.red   = clamp_channel(r_luma_term + i_terms.red);
        o_pixel.green = clamp_channel(r_luma_term + i_terms.green);
        o_pixel.blue  = clamp_channel(r_luma_term + i_terms.blue);
    end

endmodule

`default_nettype wire

// ===== design/yuyv_to_rgb888_converter.sv =====
// top level: yuyv macropixel to two rgb888 pixels (one on a tail), two lanes and merge register
// an accepted request is registered in stage one (luma and chroma terms), then in the result register
// throughput: one request per cycle, sustained while the output is not stalled
// the result register holds while stalled; stage one can still take one request behind it
// synchronous active-low reset clears the valid flags of both stages
`default_nettype none

module yuyv_to_rgb888_converter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire y2r_pkg::t_yuyv_req  i_req,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output y2r_pkg::t_rgb_res        o_res
);

    logic                   adv_out;
    logic                   adv_s1;
    logic                   load_s1;
    logic                   r_s1_valid;
    logic                   n_s1_valid;
    logic                   r_s1_tail;
    logic                   r_out_valid;
    logic                   n_out_valid;
    y2r_pkg::t_rgb_res      r_out;
    y2r_pkg::t_rgb_res      n_out;
    y2r_pkg::t_chroma_terms terms;
    y2r_pkg::t_pixel        pix_first;
    y2r_pkg::t_pixel        pix_second;

    assign adv_out = !r_out_valid || !i_stall;
    assign adv_s1  = !r_s1_valid || adv_out;
    assign load_s1 = adv_s1 && i_valid;
    assign o_stall = !adv_s1;

    y2r_chroma u_chroma (
        .i_clk                (i_clk),
        .i_en                 (load_s1),
        .i_chroma_blue        (i_req.chroma_blue),
        .i_chroma_red         (i_req.chroma_red),
        .i_tail_single        (i_req.tail_single),
        .i_red_chroma_present (i_req.red_chroma_present),
        .o_terms              (terms)
    );

    y2r_lane u_lane_first (
        .i_clk   (i_clk),
        .i_en    (load_s1),
        .i_luma  (i_req.luma_first),
        .i_terms (terms),
        .o_pixel (pix_first)
    );

    y2r_lane u_lane_second (
        .i_clk   (i_clk),
        .i_en    (load_s1),
        .i_luma  (i_req.luma_second),
        .i_terms (terms),
        .o_pixel (pix_second)
    );

    // merge lanes; tail drops the second pixel
    always_comb begin
        n_out.red_first   = pix_first.red;
        n_out.green_first = pix_first.green;
        n_out.blue_first  = pix_first.blue;
        if (r_s1_tail) begin
            n_out.red_second   = 8'd0;
            n_out.green_second = 8'd0;
            n_out.blue_second  = 8'd0;
            n_out.second_valid = 1'b0;
        end else begin
            n_out.red_second   = pix_second.red;
            n_out.green_second = pix_second.green;
            n_out.blue_second  = pix_second.blue;
            n_out.second_valid = 1'b1;
        end
    end

    assign n_s1_valid  = adv_s1 ? i_valid : r_s1_valid;
    assign n_out_valid = adv_out ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_tail <= i_req.tail_single;
        end
        if (adv_out && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

// ===== design/y2r_checker.sv =====
// port-level checks for the yuyv to rgb888 converter and their bind
`default_nettype none

module y2r_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               o_stall,
    input  wire logic               o_valid,
    input  wire logic               i_stall,
    input  wire y2r_pkg::t_rgb_res  o_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    // input is only held off when the result register is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // tail result carries a zero second pixel
    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.second_valid |->
            o_res.red_second == 8'd0 && o_res.green_second == 8'd0 &&
            o_res.blue_second == 8'd0)
        else $error("tail result has nonzero second pixel");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a request taken into an idle pipe shows up after stage one and the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> ##1 o_valid)
        else $error("result missing after request");

endmodule

bind yuyv_to_rgb888_converter y2r_checker u_y2r_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

`default_nettype wire
